// ===== hdl/fkf_pkg.sv =====
// ----------------------------------------------------------------------------
// fkf_pkg
// Shared types, constants and fixed-point helpers of the three-state
// Kalman filter core.
// ----------------------------------------------------------------------------
package fkf_pkg;

    // Number formats.
    localparam int WORD_BITS    = 64;
    localparam int FRAC_BITS    = 44;
    localparam int HALF_BITS    = WORD_BITS / 2;
    localparam int PROD_BITS    = 2 * WORD_BITS;
    localparam int IO_BITS      = 32;
    localparam int IO_FRAC      = 16;
    localparam int IO_SHIFT     = FRAC_BITS - IO_FRAC;
    localparam int DIV_STEPS    = 2 * WORD_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // State memory geometry.
    localparam int MEM_DEPTH    = 64;
    localparam int MEM_AW       = $clog2(MEM_DEPTH);

    // Configuration port.
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS-1:0]        uword_t;
    typedef logic [MEM_AW-1:0]           addr_t;
    typedef logic [PROD_BITS-1:0]        prod_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'd1;
    localparam logic [CFG_DATA_W-1:0] R_RESET              = 32'd65536;

    // Word limits and filter constants, rounded to nearest and clipped.
    localparam uword_t WMAX    = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t  W_MAX   = word_t'(WMAX);
    localparam word_t  W_MIN   = word_t'(WMAX + uword_t'(1));
    localparam uword_t ONE_RAW = uword_t'(1) << FRAC_BITS;
    localparam uword_t A1_RAW  = (ONE_RAW + uword_t'(1250)) / uword_t'(2500);
    localparam uword_t A2_RAW  = (ONE_RAW + uword_t'(6250000)) / uword_t'(12500000);
    localparam uword_t A3_RAW  = (ONE_RAW + uword_t'(64'd46875000000))
                                 / uword_t'(64'd93750000000);
    localparam word_t  K_ONE   = word_t'((ONE_RAW > WMAX) ? WMAX : ONE_RAW);
    localparam word_t  K_A1    = word_t'((A1_RAW > WMAX) ? WMAX : A1_RAW);
    localparam word_t  K_A2    = word_t'((A2_RAW > WMAX) ? WMAX : A2_RAW);
    localparam word_t  K_A3    = word_t'((A3_RAW > WMAX) ? WMAX : A3_RAW);

    // Memory map: state first, then scratch entries of one step.
    localparam addr_t AD_X     = addr_t'(0);
    localparam addr_t AD_P     = addr_t'(3);
    localparam addr_t AD_XM    = addr_t'(12);
    localparam addr_t AD_AP    = addr_t'(15);
    localparam addr_t AD_PM    = addr_t'(24);
    localparam addr_t AD_K     = addr_t'(33);
    localparam addr_t AD_MK    = addr_t'(36);
    localparam addr_t AD_TMP   = addr_t'(39);
    localparam addr_t AD_S     = addr_t'(40);
    localparam addr_t AD_INNOV = addr_t'(41);

    typedef enum logic [1:0] {
        OP_MAC,
        OP_ADD,
        OP_SUB,
        OP_DIV
    } op_t;

    typedef enum logic [3:0] {
        SRC_MEM,
        SRC_ZERO,
        SRC_ONE,
        SRC_A1,
        SRC_A2,
        SRC_A3,
        SRC_Q,
        SRC_R,
        SRC_Z
    } src_t;

    typedef enum logic [3:0] {
        PH_XM,
        PH_AP,
        PH_PAT,
        PH_Q,
        PH_K,
        PH_INNOV,
        PH_X,
        PH_MK,
        PH_P
    } phase_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_RND,
        ALU_ACC,
        ALU_ADD,
        ALU_DIV,
        ALU_DRND
    } alu_state_t;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_READ,
        CT_ISSUE,
        CT_WAIT
    } ctrl_state_t;

    // One micro-operation of the step program.
    typedef struct packed {
        op_t        op;
        src_t       a_src;
        addr_t      a_addr;
        src_t       b_src;
        addr_t      b_addr;
        logic       acc_en;
        logic       wr_en;
        addr_t      wr_addr;
        logic       x_cap;
        logic [1:0] x_idx;
    } uop_t;

    typedef struct packed {
        word_t value;
        logic  ovf;
    } sat_t;

    typedef struct packed {
        logic [IO_BITS-1:0] value;
        logic               ovf;
    } narrow_t;

    // Magnitude of a signed word; the most negative word maps to 2^(W-1).
    function automatic uword_t mag(input word_t v);
        return v[WORD_BITS-1] ? (uword_t'(0) - uword_t'(v)) : uword_t'(v);
    endfunction

    // Apply a sign to a magnitude and saturate to the word range.
    function automatic sat_t pack(input logic neg, input logic hi_nz, input uword_t lo);
        uword_t lim;
        uword_t v;
        sat_t   r;
        lim   = WMAX + uword_t'(neg);
        v     = lo;
        r.ovf = 1'b0;
        if (hi_nz || (lo > lim))
        begin
            r.ovf = 1'b1;
            v     = lim;
        end
        r.value = neg ? word_t'(uword_t'(0) - v) : word_t'(v);
        return r;
    endfunction

    // Saturating add or subtract.
    function automatic sat_t sat_addsub(input word_t a, input word_t b, input logic sub);
        logic signed [WORD_BITS:0] s;
        sat_t r;
        s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
        r.ovf   = (s[WORD_BITS] != s[WORD_BITS-1]);
        r.value = r.ovf ? (s[WORD_BITS] ? W_MIN : W_MAX) : s[WORD_BITS-1:0];
        return r;
    endfunction

    // Widen a sign and magnitude of the port format to the internal format.
    function automatic sat_t widen(input logic neg, input logic [IO_BITS:0] m);
        logic [WORD_BITS+IO_BITS:0] w;
        w = {{WORD_BITS{1'b0}}, m} << IO_SHIFT;
        return pack(neg, |w[WORD_BITS+IO_BITS:WORD_BITS], w[WORD_BITS-1:0]);
    endfunction

    // Round an internal word to the port format and saturate it.
    function automatic narrow_t narrow(input word_t v);
        logic    neg;
        uword_t  m;
        uword_t  lim;
        narrow_t r;
        neg   = v[WORD_BITS-1];
        m     = (mag(v) + (uword_t'(1) << (IO_SHIFT - 1))) >> IO_SHIFT;
        lim   = uword_t'({1'b0, {(IO_BITS-1){1'b1}}}) + uword_t'(neg);
        r.ovf = 1'b0;
        if (m > lim)
        begin
            r.ovf = 1'b1;
            m     = lim;
        end
        m       = neg ? (uword_t'(0) - m) : m;
        r.value = m[IO_BITS-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/fkf_meas_if.sv =====
// ----------------------------------------------------------------------------
// fkf_meas_if
// Measurement channel: valid, ready and one velocity sample.
// ----------------------------------------------------------------------------
interface fkf_meas_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] measured_velocity;

    modport source (output valid, output measured_velocity, input ready);
    modport sink   (input valid, input measured_velocity, output ready);

endinterface

// ===== hdl/fkf_est_if.sv =====
// ----------------------------------------------------------------------------
// fkf_est_if
// Estimate channel: valid, ready and the updated state estimate.
// ----------------------------------------------------------------------------
interface fkf_est_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_acceleration;
    logic               overflow_flag;

    modport source (output valid, output est_position, output est_velocity,
                    output est_acceleration, output overflow_flag, input ready);
    modport sink   (input valid, input est_position, input est_velocity,
                    input est_acceleration, input overflow_flag, output ready);

endinterface

// ===== hdl/kalman_filter_three_state_core.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_three_state_core
// Constant-acceleration Kalman filter with a scalar velocity measurement.
// Estimate and covariance live in a two-read-port RAM; a sequencer runs the
// step as micro-operations on one shared multi-cycle arithmetic unit.
//
//   Channel   Role   Payload
//   meas      sink   measured_velocity
//   est       source est_position, est_velocity, est_acceleration,
//                    overflow_flag
//   cfg_*     write  cfg_index selects process or measurement noise
//
// One measurement runs from acceptance to result as 128 micro-operations,
// each a read state, an issue state and a wait on the arithmetic unit for a
// multiply-accumulate, an add or subtract, or one of the three gain
// divisions. One item is in work at a time; each operation finishes its
// write before the next read, so no entry is accessed twice at once. Reset
// zeroes estimate and covariance through per-entry valid bits. A finished
// result waits in the output register while the next measurement is accepted.
// ----------------------------------------------------------------------------
module kalman_filter_three_state_core import fkf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    fkf_meas_if.sink              meas,
    fkf_est_if.source             est,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_state_t           state_reg, state_next;
    logic [CFG_DATA_W-1:0] q_cfg_reg, r_cfg_reg;
    word_t                 z_reg, acc_reg;
    logic                  flag_reg;
    logic [MEM_DEPTH-1:0]  valid_reg;
    logic                  va_reg, vb_reg;
    word_t                 xest_reg [3];
    logic [IO_BITS-1:0]    pos_reg, vel_reg, accel_reg;
    logic                  ovf_out_reg, est_valid_reg;
    logic                  fin_reg;

    uop_t   uop;
    logic   seq_last, seq_adv;
    logic   alu_start, alu_done, alu_ovf;
    word_t  alu_result, op_a, op_b;
    uword_t rdata_a, rdata_b;
    word_t  mem_a, mem_b;
    logic   ram_we, load_out, out_free, meas_take;
    sat_t   z_w, q_w, r_w;
    narrow_t n0, n1, n2;

    // Widened inputs and configuration.
    always_comb
    begin
        z_w = widen(meas.measured_velocity[IO_BITS-1],
                    meas.measured_velocity[IO_BITS-1]
                    ? ((IO_BITS+1)'(1) << IO_BITS) - {1'b0, meas.measured_velocity}
                    : {1'b0, meas.measured_velocity});
        q_w = widen(1'b0, {1'b0, q_cfg_reg});
        r_w = widen(1'b0, {1'b0, r_cfg_reg});
    end

    // Operand selection; an entry never written reads as zero.
    function automatic word_t pick(input src_t s, input word_t m, input word_t q,
                                   input word_t r, input word_t z);
        word_t v;
        unique case (s)
            SRC_MEM:  v = m;
            SRC_ONE:  v = K_ONE;
            SRC_A1:   v = K_A1;
            SRC_A2:   v = K_A2;
            SRC_A3:   v = K_A3;
            SRC_Q:    v = q;
            SRC_R:    v = r;
            SRC_Z:    v = z;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        mem_a = va_reg ? word_t'(rdata_a) : '0;
        mem_b = vb_reg ? word_t'(rdata_b) : '0;
        op_a  = pick(uop.a_src, mem_a, q_w.value, r_w.value, z_reg);
        op_b  = pick(uop.b_src, mem_b, q_w.value, r_w.value, z_reg);
    end

    fkf_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (seq_adv),
        .uop     (uop),
        .last    (seq_last)
    );

    fkf_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (uop.op),
        .a      (op_a),
        .b      (op_b),
        .acc    (acc_reg),
        .acc_en (uop.acc_en),
        .done   (alu_done),
        .result (alu_result),
        .ovf    (alu_ovf)
    );

    fkf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (uop.wr_addr),
        .wdata   (uword_t'(alu_result)),
        .raddr_a (uop.a_addr),
        .rdata_a (rdata_a),
        .raddr_b (uop.b_addr),
        .rdata_b (rdata_b)
    );

    // Narrowed estimates for the output register.
    always_comb
    begin
        n0 = narrow(xest_reg[0]);
        n1 = narrow(xest_reg[1]);
        n2 = narrow(xest_reg[2]);
    end

    // Controller next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CT_IDLE:  state_next = (meas.valid && fin_reg == 1'b0) ? CT_READ : CT_IDLE;
            CT_READ:  state_next = CT_ISSUE;
            CT_ISSUE: state_next = CT_WAIT;
            default:
            begin
                if (alu_done)
                begin
                    state_next = seq_last ? CT_IDLE : CT_READ;
                end
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        out_free  = !est_valid_reg || est.ready;
        meas_take = (state_reg == CT_IDLE) && !fin_reg && meas.valid;
        alu_start = (state_reg == CT_ISSUE);
        seq_adv   = (state_reg == CT_WAIT) && alu_done;
        ram_we    = seq_adv && uop.wr_en;
        load_out  = fin_reg && out_free;
    end

    assign meas.ready           = (state_reg == CT_IDLE) && !fin_reg;
    assign est.valid            = est_valid_reg;
    assign est.est_position     = pos_reg;
    assign est.est_velocity     = vel_reg;
    assign est.est_acceleration = accel_reg;
    assign est.overflow_flag    = ovf_out_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CT_IDLE;
            q_cfg_reg     <= '0;
            r_cfg_reg     <= R_RESET;
            valid_reg     <= '0;
            fin_reg       <= 1'b0;
            est_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PROCESS_NOISE:     q_cfg_reg <= cfg_data;
                    CFG_MEASUREMENT_NOISE: r_cfg_reg <= cfg_data;
                    default:               q_cfg_reg <= q_cfg_reg;
                endcase
            end
            if (ram_we)
            begin
                valid_reg[uop.wr_addr] <= 1'b1;
            end
            // A finished step holds until the output register is free.
            if (seq_adv && seq_last)
            begin
                fin_reg <= 1'b1;
            end
            else if (load_out)
            begin
                fin_reg <= 1'b0;
            end
            if (load_out)
            begin
                est_valid_reg <= 1'b1;
            end
            else if (est.ready)
            begin
                est_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        va_reg <= valid_reg[uop.a_addr];
        vb_reg <= valid_reg[uop.b_addr];
        if (meas_take)
        begin
            z_reg    <= z_w.value;
            flag_reg <= z_w.ovf | q_w.ovf | r_w.ovf;
        end
        if (seq_adv)
        begin
            acc_reg  <= alu_result;
            flag_reg <= flag_reg | alu_ovf;
            if (uop.x_cap)
            begin
                xest_reg[uop.x_idx] <= alu_result;
            end
        end
        if (load_out)
        begin
            pos_reg     <= n0.value;
            vel_reg     <= n1.value;
            accel_reg   <= n2.value;
            ovf_out_reg <= flag_reg | n0.ovf | n1.ovf | n2.ovf;
        end
    end

endmodule

// ===== hdl/fkf_ram.sv =====
// ----------------------------------------------------------------------------
// fkf_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module fkf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hdl/fkf_alu.sv =====
// ----------------------------------------------------------------------------
// fkf_alu
// Multi-cycle fixed-point unit: multiply-accumulate from four 32x32 partial
// products, saturating add and subtract, and a bit-serial rounding divider.
// ----------------------------------------------------------------------------
module fkf_alu import fkf_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  op_t   op,
    input  word_t a,
    input  word_t b,
    input  word_t acc,
    input  logic  acc_en,
    output logic  done,
    output word_t result,
    output logic  ovf
);

    alu_state_t           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    op_t                  op_reg;
    word_t                a_reg, b_reg, acc_reg, p_reg;
    uword_t               ma_reg, mb_reg, rem_reg;
    logic                 neg_reg, dz_reg, ovf_reg;
    prod_t                prod_reg, num_reg, quo_reg;

    logic [HALF_BITS-1:0] half_a, half_b;
    uword_t               pp;
    prod_t                pp_sh, rnd_t, quo_r;
    sat_t                 mul_pk, acc_sum, add_res, div_pk;
    uword_t               rem_sh, rem_new;
    logic                 take, round_up;

    // Partial product selected by the step count.
    always_comb
    begin
        half_a = cnt_reg[1] ? ma_reg[WORD_BITS-1:HALF_BITS] : ma_reg[HALF_BITS-1:0];
        half_b = cnt_reg[0] ? mb_reg[WORD_BITS-1:HALF_BITS] : mb_reg[HALF_BITS-1:0];
        pp     = uword_t'(half_a) * uword_t'(half_b);
        unique case (cnt_reg[1:0])
            2'd0:    pp_sh = {{WORD_BITS{1'b0}}, pp};
            2'd3:    pp_sh = {pp, {WORD_BITS{1'b0}}};
            default: pp_sh = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
        endcase
    end

    // Rounding of the product; saturating accumulate and add.
    always_comb
    begin
        rnd_t   = prod_reg + (prod_t'(1) << (FRAC_BITS - 1));
        mul_pk  = pack(neg_reg, |rnd_t[PROD_BITS-1:FRAC_BITS+WORD_BITS],
                       rnd_t[FRAC_BITS+WORD_BITS-1:FRAC_BITS]);
        acc_sum = sat_addsub(acc_reg, p_reg, 1'b0);
        add_res = sat_addsub(a_reg, b_reg, op_reg == OP_SUB);
    end

    // One restoring division step and the final rounding.
    always_comb
    begin
        rem_sh   = {rem_reg[WORD_BITS-2:0], num_reg[PROD_BITS-1]};
        take     = rem_reg[WORD_BITS-1] || (rem_sh >= mb_reg);
        rem_new  = take ? (rem_sh - mb_reg) : rem_sh;
        round_up = (rem_reg >= (mb_reg - rem_reg));
        quo_r    = quo_reg + prod_t'(round_up);
        div_pk   = pack(neg_reg, |quo_r[PROD_BITS-1:WORD_BITS], quo_r[WORD_BITS-1:0]);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ALU_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        OP_MAC:  state_next = ALU_MUL;
                        OP_DIV:  state_next = (b == '0) ? ALU_DRND : ALU_DIV;
                        default: state_next = ALU_ADD;
                    endcase
                end
            end
            ALU_MUL:  state_next = (cnt_reg[1:0] == 2'd3) ? ALU_RND : ALU_MUL;
            ALU_RND:  state_next = ALU_ACC;
            ALU_DIV:  state_next = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) ? ALU_DRND
                                                                           : ALU_DIV;
            default:  state_next = ALU_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        done   = 1'b0;
        result = acc_sum.value;
        ovf    = ovf_reg;
        unique case (state_reg)
            ALU_ACC:
            begin
                done   = 1'b1;
                result = acc_sum.value;
                ovf    = ovf_reg | acc_sum.ovf;
            end
            ALU_ADD:
            begin
                done   = 1'b1;
                result = add_res.value;
                ovf    = add_res.ovf;
            end
            ALU_DRND:
            begin
                done = 1'b1;
                if (dz_reg)
                begin
                    // Zero divisor: zero over zero is zero, else saturate by sign.
                    result = (a_reg == '0) ? '0 : (a_reg[WORD_BITS-1] ? W_MIN : W_MAX);
                    ovf    = (a_reg != '0);
                end
                else
                begin
                    result = div_pk.value;
                    ovf    = div_pk.ovf;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ALU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ALU_IDLE)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ALU_IDLE:
            begin
                if (start)
                begin
                    op_reg   <= op;
                    a_reg    <= a;
                    b_reg    <= b;
                    acc_reg  <= acc_en ? acc : '0;
                    ma_reg   <= mag(a);
                    mb_reg   <= mag(b);
                    neg_reg  <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
                    dz_reg   <= (b == '0);
                    ovf_reg  <= 1'b0;
                    prod_reg <= '0;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    num_reg  <= prod_t'(mag(a)) << FRAC_BITS;
                end
            end
            ALU_MUL:
            begin
                prod_reg <= prod_reg + pp_sh;
            end
            ALU_RND:
            begin
                p_reg   <= mul_pk.value;
                ovf_reg <= ovf_reg | mul_pk.ovf;
            end
            ALU_DIV:
            begin
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[PROD_BITS-2:0], take};
                num_reg <= num_reg << 1;
            end
            default:
            begin
                p_reg <= p_reg;
            end
        endcase
    end

endmodule

// ===== hdl/fkf_seq.sv =====
// ----------------------------------------------------------------------------
// fkf_seq
// Step program sequencer: walks the phases of one filter step with nested
// counters and decodes each position into a micro-operation.
// ----------------------------------------------------------------------------
module fkf_seq import fkf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    output uop_t uop,
    output logic last
);

    phase_t     phase_reg, phase_next;
    logic [1:0] i_reg, i_next, j_reg, j_next;
    logic [2:0] k_reg, k_next;
    logic [1:0] i_max, j_max;
    logic [2:0] k_max;
    logic [1:0] km1;

    // Row-major index of a 3x3 element.
    function automatic addr_t idx3(input logic [1:0] r, input logic [1:0] c);
        return addr_t'({r, 1'b0}) + addr_t'(r) + addr_t'(c);
    endfunction

    // Element of the transition matrix A; the offsets are compared at three
    // bits so that the row index plus two cannot wrap onto column zero.
    function automatic src_t a_elem(input logic [1:0] r, input logic [1:0] c);
        src_t s;
        s = SRC_ZERO;
        if (r == c)
        begin
            s = SRC_ONE;
        end
        else if ({1'b0, c} == ({1'b0, r} + 3'd1))
        begin
            s = SRC_A1;
        end
        else if ({1'b0, c} == ({1'b0, r} + 3'd2))
        begin
            s = SRC_A2;
        end
        return s;
    endfunction

    // Element of the noise input vector G.
    function automatic src_t g_elem(input logic [1:0] r);
        src_t s;
        unique case (r)
            2'd0:    s = SRC_A3;
            2'd1:    s = SRC_A2;
            default: s = SRC_A1;
        endcase
        return s;
    endfunction

    // Loop bounds of each phase.
    always_comb
    begin
        i_max = 2'd0;
        j_max = 2'd0;
        k_max = 3'd0;
        unique case (phase_reg)
            PH_XM:    k_max = 3'd5;
            PH_K:     k_max = 3'd3;
            PH_INNOV: k_max = 3'd0;
            PH_X:
            begin
                i_max = 2'd2;
                k_max = 3'd1;
            end
            PH_MK:    i_max = 2'd2;
            default:
            begin
                i_max = 2'd2;
                j_max = 2'd2;
                k_max = 3'd2;
            end
        endcase
    end

    assign last = (phase_reg == PH_P) && (i_reg == i_max) && (j_reg == j_max)
                  && (k_reg == k_max);

    // Next position: k fastest, then j, then i, then the phase.
    always_comb
    begin
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        if (advance)
        begin
            if (k_reg != k_max)
            begin
                k_next = k_reg + 3'd1;
            end
            else
            begin
                k_next = 3'd0;
                if (j_reg != j_max)
                begin
                    j_next = j_reg + 2'd1;
                end
                else
                begin
                    j_next = 2'd0;
                    if (i_reg != i_max)
                    begin
                        i_next = i_reg + 2'd1;
                    end
                    else
                    begin
                        i_next = 2'd0;
                        unique case (phase_reg)
                            PH_XM:    phase_next = PH_AP;
                            PH_AP:    phase_next = PH_PAT;
                            PH_PAT:   phase_next = PH_Q;
                            PH_Q:     phase_next = PH_K;
                            PH_K:     phase_next = PH_INNOV;
                            PH_INNOV: phase_next = PH_X;
                            PH_X:     phase_next = PH_MK;
                            PH_MK:    phase_next = PH_P;
                            default:  phase_next = PH_XM;
                        endcase
                    end
                end
            end
        end
    end

    // Micro-operation decode.
    always_comb
    begin
        km1     = k_reg[1:0] - 2'd1;
        uop     = '{op: OP_ADD, a_src: SRC_MEM, a_addr: AD_X, b_src: SRC_ZERO,
                    b_addr: AD_X, acc_en: 1'b0, wr_en: 1'b0, wr_addr: AD_TMP,
                    x_cap: 1'b0, x_idx: i_reg};
        unique case (phase_reg)
            PH_XM:
            begin
                // Predicted estimate xm = A*x.
                unique case (k_reg)
                    3'd0:
                    begin
                        uop.a_addr = AD_X;
                    end
                    3'd1:
                    begin
                        uop.op     = OP_MAC;
                        uop.acc_en = 1'b1;
                        uop.a_src  = SRC_A1;
                        uop.b_src  = SRC_MEM;
                        uop.b_addr = AD_X + addr_t'(1);
                    end
                    3'd2:
                    begin
                        uop.op      = OP_MAC;
                        uop.acc_en  = 1'b1;
                        uop.a_src   = SRC_A2;
                        uop.b_src   = SRC_MEM;
                        uop.b_addr  = AD_X + addr_t'(2);
                        uop.wr_en   = 1'b1;
                        uop.wr_addr = AD_XM;
                    end
                    3'd3:
                    begin
                        uop.a_addr = AD_X + addr_t'(1);
                    end
                    3'd4:
                    begin
                        uop.op      = OP_MAC;
                        uop.acc_en  = 1'b1;
                        uop.a_src   = SRC_A1;
                        uop.b_src   = SRC_MEM;
                        uop.b_addr  = AD_X + addr_t'(2);
                        uop.wr_en   = 1'b1;
                        uop.wr_addr = AD_XM + addr_t'(1);
                    end
                    default:
                    begin
                        uop.a_addr  = AD_X + addr_t'(2);
                        uop.wr_en   = 1'b1;
                        uop.wr_addr = AD_XM + addr_t'(2);
                    end
                endcase
            end
            PH_AP:
            begin
                // AP = A*P.
                uop.op      = OP_MAC;
                uop.acc_en  = (k_reg != 3'd0);
                uop.a_src   = a_elem(i_reg, k_reg[1:0]);
                uop.b_src   = SRC_MEM;
                uop.b_addr  = AD_P + idx3(k_reg[1:0], j_reg);
                uop.wr_en   = (k_reg == k_max);
                uop.wr_addr = AD_AP + idx3(i_reg, j_reg);
            end
            PH_PAT:
            begin
                // PM = AP*A^T.
                uop.op      = OP_MAC;
                uop.acc_en  = (k_reg != 3'd0);
                uop.a_addr  = AD_AP + idx3(i_reg, k_reg[1:0]);
                uop.b_src   = a_elem(j_reg, k_reg[1:0]);
                uop.wr_en   = (k_reg == k_max);
                uop.wr_addr = AD_PM + idx3(i_reg, j_reg);
            end
            PH_Q:
            begin
                // PM += (g_i*g_j)*q.
                unique case (k_reg)
                    3'd0:
                    begin
                        uop.op      = OP_MAC;
                        uop.a_src   = g_elem(i_reg);
                        uop.b_src   = g_elem(j_reg);
                        uop.wr_en   = 1'b1;
                        uop.wr_addr = AD_TMP;
                    end
                    3'd1:
                    begin
                        uop.a_addr = AD_PM + idx3(i_reg, j_reg);
                    end
                    default:
                    begin
                        uop.op      = OP_MAC;
                        uop.acc_en  = 1'b1;
                        uop.a_addr  = AD_TMP;
                        uop.b_src   = SRC_Q;
                        uop.wr_en   = 1'b1;
                        uop.wr_addr = AD_PM + idx3(i_reg, j_reg);
                    end
                endcase
            end
            PH_K:
            begin
                // Innovation variance, then the gain column.
                if (k_reg == 3'd0)
                begin
                    uop.a_addr  = AD_PM + addr_t'(4);
                    uop.b_src   = SRC_R;
                    uop.wr_en   = 1'b1;
                    uop.wr_addr = AD_S;
                end
                else
                begin
                    uop.op      = OP_DIV;
                    uop.a_addr  = AD_PM + idx3(km1, 2'd1);
                    uop.b_src   = SRC_MEM;
                    uop.b_addr  = AD_S;
                    uop.wr_en   = 1'b1;
                    uop.wr_addr = AD_K + addr_t'(km1);
                end
            end
            PH_INNOV:
            begin
                uop.op      = OP_SUB;
                uop.a_src   = SRC_Z;
                uop.b_src   = SRC_MEM;
                uop.b_addr  = AD_XM + addr_t'(1);
                uop.wr_en   = 1'b1;
                uop.wr_addr = AD_INNOV;
            end
            PH_X:
            begin
                // x = xm + K*innovation.
                if (k_reg == 3'd0)
                begin
                    uop.a_addr = AD_XM + addr_t'(i_reg);
                end
                else
                begin
                    uop.op      = OP_MAC;
                    uop.acc_en  = 1'b1;
                    uop.a_addr  = AD_K + addr_t'(i_reg);
                    uop.b_src   = SRC_MEM;
                    uop.b_addr  = AD_INNOV;
                    uop.wr_en   = 1'b1;
                    uop.wr_addr = AD_X + addr_t'(i_reg);
                    uop.x_cap   = 1'b1;
                end
            end
            PH_MK:
            begin
                // Middle column of I - K*C.
                uop.op      = OP_SUB;
                uop.a_src   = (i_reg == 2'd1) ? SRC_ONE : SRC_ZERO;
                uop.b_src   = SRC_MEM;
                uop.b_addr  = AD_K + addr_t'(i_reg);
                uop.wr_en   = 1'b1;
                uop.wr_addr = AD_MK + addr_t'(i_reg);
            end
            default:
            begin
                // P = (I - K*C)*PM.
                uop.op      = OP_MAC;
                uop.acc_en  = (k_reg != 3'd0);
                uop.a_src   = (k_reg == 3'd1) ? SRC_MEM
                              : ((k_reg[1:0] == i_reg) ? SRC_ONE : SRC_ZERO);
                uop.a_addr  = AD_MK + addr_t'(i_reg);
                uop.b_src   = SRC_MEM;
                uop.b_addr  = AD_PM + idx3(k_reg[1:0], j_reg);
                uop.wr_en   = (k_reg == k_max);
                uop.wr_addr = AD_P + idx3(i_reg, j_reg);
            end
        endcase
    end

    // Position registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_XM;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
            k_reg     <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ===== verif/kalman_filter_three_state_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_three_state_checker
// Watches the measurement, estimate and configuration ports of the filter
// core. It keeps its own copy of the filter state, predicts every estimate
// and compares it field by field with what the core delivers.
// ----------------------------------------------------------------------------
module kalman_filter_three_state_checker import fkf_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    fkf_meas_if                   meas,
    fkf_est_if                    est,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        logic        ovf;
    } estimate_t;

    localparam logic [63:0] C_ONE = 64'd1 << 44;
    localparam logic [63:0] C_A1  = (C_ONE + 64'd1250) / 64'd2500;
    localparam logic [63:0] C_A2  = (C_ONE + 64'd6250000) / 64'd12500000;
    localparam logic [63:0] C_A3  = (C_ONE + 64'd46875000000) / 64'd93750000000;
    localparam logic [127:0] LIM_POS = 128'h7FFF_FFFF_FFFF_FFFF;

    // Shadow state of the filter.
    logic [31:0] shadow_q;
    logic [31:0] shadow_r;
    word_t       shadow_x [3];
    word_t       shadow_p [9];
    logic        step_sat;
    estimate_t   estimate_queue [$];

    // Magnitude of a signed word as an unsigned value.
    function automatic logic [63:0] umag(input word_t v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    // Apply a sign to a wide magnitude and clamp it to the word range.
    function automatic word_t clamp_word(input logic neg, input logic [127:0] m);
        logic [127:0] lim;
        logic [63:0]  v;
        lim = LIM_POS + 128'(neg);
        if (m > lim)
        begin
            step_sat = 1'b1;
            m = lim;
        end
        v = m[63:0];
        return neg ? word_t'(64'd0 - v) : word_t'(v);
    endfunction

    function automatic word_t fx_mul(input word_t a, input word_t b);
        logic [127:0] p;
        p = {64'd0, umag(a)} * {64'd0, umag(b)};
        p = p + (128'd1 << 43);
        return clamp_word(a[63] ^ b[63], p >> 44);
    endfunction

    function automatic word_t fx_div(input word_t a, input word_t d);
        logic [127:0] n;
        logic [127:0] dm;
        logic [127:0] quo;
        logic [127:0] rem;
        if (d == 0)
        begin
            if (a == 0)
                return 0;
            step_sat = 1'b1;
            return (a > 0) ? W_MAX : W_MIN;
        end
        n   = {64'd0, umag(a)} << 44;
        dm  = {64'd0, umag(d)};
        quo = n / dm;
        rem = n % dm;
        if (rem >= dm - rem)
            quo = quo + 128'd1;
        return clamp_word(a[63] ^ d[63], quo);
    endfunction

    function automatic word_t fx_add(input word_t a, input word_t b, input logic sub);
        logic signed [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63])
        begin
            step_sat = 1'b1;
            return s[64] ? W_MIN : W_MAX;
        end
        return s[63:0];
    endfunction

    function automatic word_t fx_widen(input logic neg, input logic [32:0] m);
        return clamp_word(neg, {95'd0, m} << 28);
    endfunction

    function automatic logic [31:0] fx_narrow(input word_t v);
        logic [63:0] m;
        logic [63:0] lim;
        m   = (umag(v) + (64'd1 << 27)) >> 28;
        lim = 64'h7FFF_FFFF + 64'(v[63]);
        if (m > lim)
        begin
            step_sat = 1'b1;
            m = lim;
        end
        return v[63] ? (32'd0 - m[31:0]) : m[31:0];
    endfunction

    // 3x3 product with saturating accumulation, left to right.
    task automatic mat_mul(input word_t a [9], input word_t b [9], output word_t o [9]);
        word_t acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc = fx_add(acc, fx_mul(a[i*3+k], b[k*3+j]), 1'b0);
                o[i*3+j] = acc;
            end
    endtask

    // One filter step: predict, gain, update; returns the narrowed estimate.
    task automatic predict_estimate(input logic [31:0] zraw, output estimate_t e);
        word_t am [9];
        word_t at [9];
        word_t ap [9];
        word_t pm [9];
        word_t mk [9];
        word_t g  [3];
        word_t xm [3];
        word_t gain [3];
        word_t z, q, r, s, innov, d;
        step_sat = 1'b0;
        z = fx_widen(zraw[31], zraw[31] ? (33'h1_0000_0000 - {1'b0, zraw}) : {1'b0, zraw});
        q = fx_widen(1'b0, {1'b0, shadow_q});
        r = fx_widen(1'b0, {1'b0, shadow_r});
        am = '{C_ONE, C_A1, C_A2, 0, C_ONE, C_A1, 0, 0, C_ONE};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                at[i*3+j] = am[j*3+i];
        g = '{C_A3, C_A2, C_A1};
        xm[0] = fx_add(fx_add(shadow_x[0], fx_mul(C_A1, shadow_x[1]), 1'b0),
                       fx_mul(C_A2, shadow_x[2]), 1'b0);
        xm[1] = fx_add(shadow_x[1], fx_mul(C_A1, shadow_x[2]), 1'b0);
        xm[2] = shadow_x[2];
        mat_mul(am, shadow_p, ap);
        mat_mul(ap, at, pm);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                pm[i*3+j] = fx_add(pm[i*3+j], fx_mul(fx_mul(g[i], g[j]), q), 1'b0);
        s = fx_add(pm[4], r, 1'b0);
        for (int i = 0; i < 3; i++)
            gain[i] = fx_div(pm[i*3+1], s);
        innov = fx_add(z, xm[1], 1'b1);
        for (int i = 0; i < 3; i++)
            shadow_x[i] = fx_add(xm[i], fx_mul(gain[i], innov), 1'b0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                d = (i == j) ? word_t'(C_ONE) : word_t'(0);
                mk[i*3+j] = (j == 1) ? fx_add(d, gain[i], 1'b1) : d;
            end
        mat_mul(mk, pm, shadow_p);
        e.pos = fx_narrow(shadow_x[0]);
        e.vel = fx_narrow(shadow_x[1]);
        e.acc = fx_narrow(shadow_x[2]);
        e.ovf = step_sat;
    endtask

    // Track configuration, predict on each measurement, compare each estimate.
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t e;
        if (!rst_n)
        begin
            shadow_q   <= 32'd0;
            shadow_r   <= R_RESET;
            for (int i = 0; i < 3; i++) shadow_x[i] = 0;
            for (int i = 0; i < 9; i++) shadow_p[i] = 0;
            estimate_queue.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PROCESS_NOISE)
                    shadow_q <= cfg_data;
                else if (cfg_index == CFG_MEASUREMENT_NOISE)
                    shadow_r <= cfg_data;
            end
            if (meas.valid && meas.ready)
            begin
                predict_estimate(meas.measured_velocity, e);
                estimate_queue.push_back(e);
            end
            if (est.valid && est.ready)
            begin
                if (estimate_queue.size() == 0)
                begin
                    $display("%0t: unexpected estimate pos=%h vel=%h acc=%h ovf=%b", $time,
                             est.est_position, est.est_velocity, est.est_acceleration,
                             est.overflow_flag);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = estimate_queue.pop_front();
                    if (est.est_position !== e.pos || est.est_velocity !== e.vel ||
                        est.est_acceleration !== e.acc || est.overflow_flag !== e.ovf)
                    begin
                        $display("%0t: mismatch expected pos=%h vel=%h acc=%h ovf=%b", $time,
                                 e.pos, e.vel, e.acc, e.ovf);
                        $display("%0t:          actual   pos=%h vel=%h acc=%h ovf=%b", $time,
                                 est.est_position, est.est_velocity, est.est_acceleration,
                                 est.overflow_flag);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= estimate_queue.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the filter core through several noise settings with directed and
// random velocity samples, random gaps on both channels and one long output
// stall; the checker beside the core predicts and compares every estimate.
// ----------------------------------------------------------------------------
module tb;
    import fkf_pkg::*;

    localparam int IDLE_LIMIT   = 40000;
    localparam int HOLD_CYCLES  = 5000;
    localparam int RANDOM_ITEMS = 1250;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    logic                  hold_request;

    fkf_meas_if meas ();
    fkf_est_if  est ();

    kalman_filter_three_state_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas),
        .est       (est),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kalman_filter_three_state_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas       (meas),
        .est        (est),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((meas.valid && meas.ready) || (est.valid && est.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("kalman_filter_three_state_core verification failed");
            $finish;
        end
    end

    // Random gap length: mostly short, now and then long.
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(0, 3);
        return $urandom_range(20, 300);
    endfunction

    // Velocity sample: small values, full-range values or an extreme.
    function automatic logic [31:0] pick_velocity();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
        if (mode < 9)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Offer one sample and wait for its transaction.
    task automatic send_velocity(input logic [31:0] z);
        int gap;
        meas.valid             <= 1'b1;
        meas.measured_velocity <= z;
        do
            @(posedge clk);
        while (!meas.ready);
        gap = gap_length();
        if (gap > 0)
        begin
            meas.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every outstanding estimate arrive, plus some quiet cycles.
    task automatic drain();
        meas.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || est.valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_noise(input logic [31:0] q, input logic [31:0] r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PROCESS_NOISE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= CFG_MEASUREMENT_NOISE;
        cfg_data  <= r;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random stalls, and one long hold-off on request.
    initial
    begin
        est.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                est.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 70)
            begin
                est.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                est.ready <= 1'b0;
                repeat (gap_length() + 1) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] q_set [6];
        logic [31:0] r_set [6];
        meas.valid             = 1'b0;
        meas.measured_velocity = '0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_PROCESS_NOISE;
        cfg_data               = '0;
        idle_cycles            = 0;
        hold_request           = 1'b0;
        rst_n                  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero innovation variance with zero numerator first.
        write_noise(32'd0, 32'd0);
        send_velocity(32'd0);
        send_velocity(32'h7FFF_FFFF);
        send_velocity(32'h8000_0000);
        drain();
        // Default noise, field extremes and sign boundaries.
        write_noise(32'd0, R_RESET);
        send_velocity(32'h7FFF_FFFF);
        send_velocity(32'h8000_0000);
        send_velocity(32'h8000_0001);
        send_velocity(32'h0000_0001);
        send_velocity(32'hFFFF_FFFF);
        send_velocity(32'h0001_0000);
        send_velocity(32'hFFFF_0000);
        drain();
        // Largest noise terms, wide values saturating in the internal format.
        write_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_velocity(32'h7FFF_FFFF);
        send_velocity(32'h8000_0000);
        send_velocity(32'h5555_AAAA);
        send_velocity(32'hAAAA_5555);
        drain();
        // Large process noise with no measurement noise.
        write_noise(32'hFFFF_FFFF, 32'd0);
        send_velocity(32'h7FFF_FFFF);
        send_velocity(32'h8000_0000);
        send_velocity(32'h0000_0000);
        send_velocity(32'h1234_5678);
        drain();

        // Random part over a series of noise settings.
        q_set = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0000_0100, 32'hFFFF_FFFF};
        r_set = '{32'd65536, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h0000_0010, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 6)
                write_noise(q_set[ph], r_set[ph]);
            else
                write_noise($urandom, $urandom);
            if (ph == 1)
                hold_request = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS / 8; n++)
                send_velocity(pick_velocity());
            drain();
        end

        if (fail_count == 0)
            $display("kalman_filter_three_state_core verification clean");
        else
            $display("kalman_filter_three_state_core verification failed");
        $finish;
    end

endmodule
